// ===== rtl/pcvd_pkg.sv =====
// Package for the page curl vertex deformer: register indexes, constants,
// arctangent table and shared types. No dependencies.
package pcvd_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COS_ANGLE     = 3'd0,
        REG_SIN_ANGLE     = 3'd1,
        REG_CURL_POSITION = 3'd2,
        REG_CURL_RADIUS   = 3'd3,
        REG_INV_RADIUS    = 3'd4,
        REG_PAGE_HEIGHT   = 3'd5,
        REG_FLAT_MODE     = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        REGION_FLAT     = 2'd0,
        REGION_CYLINDER = 2'd1,
        REGION_FOLDED   = 2'd2
    } region_t;

    localparam logic signed [18:0] PI_Q16      = 19'sd205887;
    localparam logic signed [18:0] HALF_PI_Q16 = 19'sd102944;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    typedef struct packed {
        logic signed [17:0] cos_angle;
        logic signed [17:0] sin_angle;
        logic signed [31:0] curl_position;
        logic [30:0]        curl_radius;
        logic [30:0]        inv_radius;
        logic [30:0]        page_height;
        logic               flat_mode;
    } cfg_t;

    // Truncated Q2.30 arctangent of 2^-i
    function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
        logic signed [33:0] a;
        case (i)
            5'd0:  a = 34'sd843314856;
            5'd1:  a = 34'sd497837829;
            5'd2:  a = 34'sd263043836;
            5'd3:  a = 34'sd133525158;
            5'd4:  a = 34'sd67021686;
            5'd5:  a = 34'sd33543515;
            5'd6:  a = 34'sd16775850;
            5'd7:  a = 34'sd8388437;
            5'd8:  a = 34'sd4194282;
            5'd9:  a = 34'sd2097149;
            5'd10: a = 34'sd1048575;
            5'd11: a = 34'sd524287;
            5'd12: a = 34'sd262143;
            5'd13: a = 34'sd131071;
            5'd14: a = 34'sd65535;
            5'd15: a = 34'sd32767;
            5'd16: a = 34'sd16383;
            5'd17: a = 34'sd8191;
            5'd18: a = 34'sd4095;
            5'd19: a = 34'sd2047;
            5'd20: a = 34'sd1023;
            5'd21: a = 34'sd511;
            5'd22: a = 34'sd255;
            5'd23: a = 34'sd127;
            5'd24: a = 34'sd63;
            5'd25: a = 34'sd31;
            5'd26: a = 34'sd15;
            5'd27: a = 34'sd7;
            5'd28: a = 34'sd3;
            5'd29: a = 34'sd1;
            default: a = 34'sd0;
        endcase
        return a;
    endfunction

endpackage

// ===== rtl/pcvd_if.sv =====
// Valid/ready stream interfaces for vertex and result beats.
// Depends on nothing.
interface pcvd_vertex_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    modport source (output valid, output vertex_x, output vertex_y, input ready);
    modport sink (input valid, input vertex_x, input vertex_y, output ready);
endinterface

interface pcvd_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic [30:0]        out_z;
    logic [1:0]         region;
    modport source (output valid, output out_x, output out_y, output out_z,
                    output region, input ready);
    modport sink (input valid, input out_x, input out_y, input out_z,
                  input region, output ready);
endinterface

// ===== rtl/page_curl_vertex_deform.sv =====
// Top level of the page curl vertex deformer: a pipeline of forward rotation,
// region choice, CORDIC, lift and back rotation. Depends on pcvd_pkg, pcvd_if,
// pcvd_cfg and pcvd_cordic_stage.
//
//  channel   dir  beat contents
//  vin       in   vertex_x, vertex_y
//  vout      out  out_x, out_y, out_z, region
//  cfg       in   cfg_we, cfg_index, cfg_data
//
// One vertex per clock while the pipe advances; the depth is set by the CORDIC
// chain and the split arc-angle product. Reset clears only the valid bits and
// loads config defaults. The pipe advances together when the output register is
// empty or being taken, so a stall holds every stage and loses nothing.
module page_curl_vertex_deform #(
    parameter int TRIG_STAGES = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    pcvd_vertex_if.sink                     vin,
    pcvd_result_if.source                   vout,
    input  logic                            cfg_we,
    input  logic [pcvd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pcvd_pkg::CFG_DATA_W-1:0] cfg_data
);
    localparam int PRE = 5;   // stages before the CORDIC
    localparam int POST = 6;  // stages after it, output register last
    localparam int NST = PRE + TRIG_STAGES + POST;

    pcvd_pkg::cfg_t cfg;
    pcvd_cfg u_cfg (.clk, .rst_n, .cfg_we, .cfg_index, .cfg_data, .cfg);

    logic [NST-1:0] vld_reg;
    logic           adv;

    // global advance: output slot free or taken
    assign adv = !vld_reg[NST-1] || vout.ready;
    assign vin.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NST-2:0], vin.valid};
    end

    // ---- stage 1: input products
    function automatic logic signed [49:0] PI_R(input logic [30:0] r);
        return 50'($signed(pcvd_pkg::PI_Q16) * $signed({1'b0, r}));
    endfunction

    logic signed [63:0] s1_xc_reg, s1_ys_reg, s1_xs_reg, s1_yc_reg;
    logic signed [31:0] s1_vx_reg, s1_vy_reg;
    logic signed [49:0] pir_next;
    logic signed [33:0] s1_pir_reg;

    assign pir_next = PI_R(cfg.curl_radius);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_xc_reg <= 64'(vin.vertex_x * cfg.cos_angle);
            s1_ys_reg <= 64'(vin.vertex_y * cfg.sin_angle);
            s1_xs_reg <= 64'(vin.vertex_x * cfg.sin_angle);
            s1_yc_reg <= 64'(vin.vertex_y * cfg.cos_angle);
            s1_vx_reg <= vin.vertex_x;
            s1_vy_reg <= vin.vertex_y;
            s1_pir_reg <= 34'(pir_next >>> 16);
        end
    end

    // ---- stage 2: rotated coordinates and bound
    logic signed [34:0] s2_rx_reg, s2_ry_reg, s2_bound_reg;
    logic signed [31:0] s2_vx_reg, s2_vy_reg;
    logic signed [33:0] s2_pir_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_rx_reg <= 35'((s1_xc_reg - s1_ys_reg) >>> 16);
            s2_ry_reg <= 35'((s1_xs_reg + s1_yc_reg) >>> 16);
            s2_bound_reg <= 35'(cfg.curl_position) + 35'(s1_pir_reg);
            s2_vx_reg <= s1_vx_reg;
            s2_vy_reg <= s1_vy_reg;
            s2_pir_reg <= s1_pir_reg;
        end
    end

    // ---- stage 3: region decision and arc distance
    logic [1:0]         s3_reg_reg;
    logic signed [34:0] s3_rx_reg, s3_ry_reg, s3_fold_reg;
    logic [35:0]        s3_d_reg;
    logic signed [31:0] s3_vx_reg, s3_vy_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (s2_rx_reg > s2_bound_reg)
                s3_reg_reg <= pcvd_pkg::REGION_FOLDED;
            else if (s2_rx_reg > 35'(cfg.curl_position))
                s3_reg_reg <= pcvd_pkg::REGION_CYLINDER;
            else
                s3_reg_reg <= pcvd_pkg::REGION_FLAT;
            s3_d_reg <= 36'(s2_rx_reg - 35'(cfg.curl_position));
            s3_fold_reg <= 35'(2 * 35'(cfg.curl_position)) + 35'(s2_pir_reg) - s2_rx_reg;
            s3_rx_reg <= s2_rx_reg;
            s3_ry_reg <= s2_ry_reg;
            s3_vx_reg <= s2_vx_reg;
            s3_vy_reg <= s2_vy_reg;
        end
    end

    // ---- stage 4: d * inv_radius, split into two partial products
    logic [52:0]        s4_lo_reg, s4_hi_reg;
    logic [1:0]         s4_reg_reg;
    logic signed [34:0] s4_rx_reg, s4_ry_reg, s4_fold_reg;
    logic signed [31:0] s4_vx_reg, s4_vy_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_lo_reg <= 53'(s3_d_reg[17:0] * cfg.inv_radius);
            s4_hi_reg <= 53'(s3_d_reg[35:18] * cfg.inv_radius);
            s4_reg_reg <= s3_reg_reg;
            s4_rx_reg <= s3_rx_reg;
            s4_ry_reg <= s3_ry_reg;
            s4_fold_reg <= s3_fold_reg;
            s4_vx_reg <= s3_vx_reg;
            s4_vy_reg <= s3_vy_reg;
        end
    end

    // ---- stage 5: alpha, saturate, fold to first quadrant
    logic [71:0] prod_a;
    logic [55:0] alpha_wide;
    logic [18:0] alpha, beta;
    logic        neg_c;

    assign prod_a = {19'd0, s4_hi_reg} * 72'd262144 + {19'd0, s4_lo_reg};
    assign alpha_wide = prod_a[71:16];
    always_comb
    begin
        alpha = (alpha_wide > 56'(pcvd_pkg::PI_Q16)) ? 19'(pcvd_pkg::PI_Q16)
                                                     : alpha_wide[18:0];
        neg_c = alpha > 19'(pcvd_pkg::HALF_PI_Q16);
        beta = neg_c ? 19'(pcvd_pkg::PI_Q16) - alpha : alpha;
    end

    typedef struct packed {
        logic [1:0]         region;
        logic               neg_c;
        logic signed [34:0] rx;
        logic signed [34:0] ry;
        logic signed [34:0] fold;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
    } side_t;

    side_t              s5_side_reg;
    logic signed [33:0] s5_z_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_side_reg <= '{s4_reg_reg, neg_c, s4_rx_reg, s4_ry_reg, s4_fold_reg,
                             s4_vx_reg, s4_vy_reg};
            s5_z_reg <= $signed({1'b0, beta, 14'd0});
        end
    end

    // ---- CORDIC chain, side data delayed alongside
    logic signed [33:0] cx [0:TRIG_STAGES];
    logic signed [33:0] cy [0:TRIG_STAGES];
    logic signed [33:0] cz [0:TRIG_STAGES];
    side_t              side_reg [1:TRIG_STAGES];

    assign cx[0] = pcvd_pkg::CORDIC_GAIN;
    assign cy[0] = '0;
    assign cz[0] = s5_z_reg;

    for (genvar g = 0; g < TRIG_STAGES; g++)
    begin : g_cordic
        pcvd_cordic_stage #(.STAGE(g)) u_stage (
            .clk, .en(adv),
            .x_in(cx[g]), .y_in(cy[g]), .z_in(cz[g]),
            .x_out(cx[g+1]), .y_out(cy[g+1]), .z_out(cz[g+1])
        );
        always_ff @(posedge clk)
        begin
            if (adv)
                side_reg[g+1] <= (g == 0) ? s5_side_reg : side_reg[(g == 0) ? 1 : g];
        end
    end

    // ---- post 1: r*sin and r*cos
    side_t              p1_side_reg;
    logic signed [65:0] p1_rs_reg, p1_rc_reg;
    logic signed [33:0] cosv;

    assign cosv = side_reg[TRIG_STAGES].neg_c ? -cx[TRIG_STAGES] : cx[TRIG_STAGES];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_side_reg <= side_reg[TRIG_STAGES];
            p1_rs_reg <= 66'($signed({1'b0, cfg.curl_radius}) * cy[TRIG_STAGES]);
            p1_rc_reg <= 66'($signed({1'b0, cfg.curl_radius}) * cosv);
        end
    end

    // ---- post 2: fx and z by region
    side_t              p2_side_reg;
    logic signed [34:0] p2_fx_reg;
    logic [30:0]        p2_z_reg;
    logic signed [36:0] zc;

    assign zc = 37'($signed({1'b0, cfg.curl_radius})) - 37'(p1_rc_reg >>> 30);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p2_side_reg <= p1_side_reg;
            case (p1_side_reg.region)
                pcvd_pkg::REGION_FOLDED:
                begin
                    p2_fx_reg <= p1_side_reg.fold;
                    p2_z_reg <= cfg.curl_radius[30] ? 31'h7FFF_FFFF
                                                    : {cfg.curl_radius[29:0], 1'b0};
                end
                pcvd_pkg::REGION_CYLINDER:
                begin
                    p2_fx_reg <= 35'(cfg.curl_position) + 35'(p1_rs_reg >>> 30);
                    p2_z_reg <= zc[36] ? 31'd0 : (zc > 37'sh7FFF_FFFF) ? 31'h7FFF_FFFF
                                                                      : zc[30:0];
                end
                default:
                begin
                    p2_fx_reg <= p1_side_reg.rx;
                    p2_z_reg <= '0;
                end
            endcase
        end
    end

    // ---- post 3/4: back rotation, 35x18 products then their sums
    side_t              p3_side_reg;
    logic [30:0]        p3_z_reg;
    logic signed [53:0] p3_fc_reg, p3_rs_reg, p3_rc_reg, p3_fs_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p3_side_reg <= p2_side_reg;
            p3_z_reg <= p2_z_reg;
            p3_fc_reg <= 54'(p2_fx_reg * cfg.cos_angle);
            p3_rs_reg <= 54'(p2_side_reg.ry * cfg.sin_angle);
            p3_rc_reg <= 54'(p2_side_reg.ry * cfg.cos_angle);
            p3_fs_reg <= 54'(p2_fx_reg * cfg.sin_angle);
        end
    end

    side_t              p4_side_reg;
    logic [30:0]        p4_z_reg;
    logic signed [38:0] p4_ox_reg, p4_t_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p4_side_reg <= p3_side_reg;
            p4_z_reg <= p3_z_reg;
            p4_ox_reg <= 39'((p3_fc_reg + p3_rs_reg) >>> 16);
            p4_t_reg <= 39'((p3_rc_reg - p3_fs_reg) >>> 16);
        end
    end

    // ---- post 5: height flip and mode select
    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        if (v > 40'sh7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        else if (v < -40'sh8000_0000)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    logic signed [31:0] p5_x_reg, p5_y_reg;
    logic [30:0]        p5_z_reg;
    logic [1:0]         p5_r_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (cfg.flat_mode)
            begin
                p5_x_reg <= p4_side_reg.vx;
                p5_y_reg <= sat32(40'($signed({1'b0, cfg.page_height}))
                                  - 40'(p4_side_reg.vy));
                p5_z_reg <= '0;
                p5_r_reg <= pcvd_pkg::REGION_FLAT;
            end
            else
            begin
                p5_x_reg <= sat32(40'(p4_ox_reg));
                p5_y_reg <= sat32(40'($signed({1'b0, cfg.page_height})) - 40'(p4_t_reg));
                p5_z_reg <= p4_z_reg;
                p5_r_reg <= p4_side_reg.region;
            end
        end
    end

    // ---- output register
    logic signed [31:0] o_x_reg, o_y_reg;
    logic [30:0]        o_z_reg;
    logic [1:0]         o_r_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            o_x_reg <= p5_x_reg;
            o_y_reg <= p5_y_reg;
            o_z_reg <= p5_z_reg;
            o_r_reg <= p5_r_reg;
        end
    end

    assign vout.valid  = vld_reg[NST-1];
    assign vout.out_x  = o_x_reg;
    assign vout.out_y  = o_y_reg;
    assign vout.out_z  = o_z_reg;
    assign vout.region = o_r_reg;

    // ---- assertions
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        vout.valid && !vout.ready |=> vout.valid && $stable(o_x_reg) && $stable(o_r_reg))
        else $error("result changed while stalled");
    a_ready_adv: assert property (@(posedge clk) disable iff (!rst_n)
        !vout.valid |-> vin.ready)
        else $error("input blocked with empty output");
    a_region_ok: assert property (@(posedge clk) disable iff (!rst_n)
        vout.valid |-> vout.region != 2'd3)
        else $error("bad region code");
    a_flat_z: assert property (@(posedge clk) disable iff (!rst_n)
        vout.valid && vout.region == pcvd_pkg::REGION_FLAT |-> vout.out_z == 31'd0)
        else $error("flat result with lift");
endmodule

// ===== rtl/pcvd_cfg.sv =====
// Configuration register file of the page curl deformer.
// Depends on pcvd_pkg.
module pcvd_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [pcvd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pcvd_pkg::CFG_DATA_W-1:0] cfg_data,
    output pcvd_pkg::cfg_t                cfg
);
    pcvd_pkg::cfg_t cfg_reg;

    // register writes, out-of-range index ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cos_angle     <= 18'sd65536;
            cfg_reg.sin_angle     <= '0;
            cfg_reg.curl_position <= '0;
            cfg_reg.curl_radius   <= '0;
            cfg_reg.inv_radius    <= 31'h7FFF_FFFF;
            cfg_reg.page_height   <= 31'd65536;
            cfg_reg.flat_mode     <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pcvd_pkg::REG_COS_ANGLE:     cfg_reg.cos_angle <= cfg_data[17:0];
                pcvd_pkg::REG_SIN_ANGLE:     cfg_reg.sin_angle <= cfg_data[17:0];
                pcvd_pkg::REG_CURL_POSITION: cfg_reg.curl_position <= cfg_data;
                pcvd_pkg::REG_CURL_RADIUS:   cfg_reg.curl_radius <= cfg_data[30:0];
                pcvd_pkg::REG_INV_RADIUS:    cfg_reg.inv_radius <= cfg_data[30:0];
                pcvd_pkg::REG_PAGE_HEIGHT:   cfg_reg.page_height <= cfg_data[30:0];
                pcvd_pkg::REG_FLAT_MODE:     cfg_reg.flat_mode <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;
endmodule

// ===== rtl/pcvd_cordic_stage.sv =====
// One rotation-mode CORDIC stage on Q2.30 values with a register after it.
// Depends on pcvd_pkg.
module pcvd_cordic_stage #(
    parameter int STAGE = 0
) (
    input  logic               clk,
    input  logic               en,
    input  logic signed [33:0] x_in,
    input  logic signed [33:0] y_in,
    input  logic signed [33:0] z_in,
    output logic signed [33:0] x_out,
    output logic signed [33:0] y_out,
    output logic signed [33:0] z_out
);
    logic signed [33:0] x_reg, y_reg, z_reg;
    logic signed [33:0] dx, dy, at;

    // arithmetic shift rounds toward minus infinity
    assign dx = y_in >>> STAGE;
    assign dy = x_in >>> STAGE;
    assign at = pcvd_pkg::atan_q30(5'(STAGE));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (!z_in[33])
            begin
                x_reg <= x_in - dx;
                y_reg <= y_in + dy;
                z_reg <= z_in - at;
            end
            else
            begin
                x_reg <= x_in + dx;
                y_reg <= y_in - dy;
                z_reg <= z_in + at;
            end
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
endmodule
